// ===== hdl/cts_pkg.sv =====
// Shared types, constants and calendar tables of the calendar timezone shift block.
package cts_pkg;

  localparam int BASE_YEAR       = 2000;
  localparam int LAST_YEAR       = BASE_YEAR + 99;
  localparam int DAYS_PER_QUAD   = 365 * 4 + 1;
  localparam int SPAN_DAYS       = 25 * DAYS_PER_QUAD;
  localparam int SECS_PER_DAY    = 86400;
  localparam int SECS_PER_HOUR   = 3600;
  localparam int SECS_PER_MIN    = 60;
  localparam int ZONE_UNIT_SECS  = 6 * 60;
  localparam int MILLIS_PER_SEC  = 1000;
  // Day 0 (2000-01-01) is a Saturday, weekday code 6.
  localparam int WEEKDAY_BIAS    = 5;

  // Reciprocal constants for division by a constant: floor(2^N / D).
  localparam int QUAD_SHIFT  = 16;
  localparam int QUAD_RECIP  = (2 ** QUAD_SHIFT) / DAYS_PER_QUAD;
  localparam int WEEK_SHIFT  = 16;
  localparam int WEEK_RECIP  = (2 ** WEEK_SHIFT) / 7;
  localparam int HOUR_SHIFT  = 17;
  localparam int HOUR_RECIP  = (2 ** HOUR_SHIFT) / SECS_PER_HOUR;
  localparam int MIN_SHIFT   = 12;
  localparam int MIN_RECIP   = (2 ** MIN_SHIFT) / SECS_PER_MIN;

  localparam int QUEUE_DEPTH_DEF = 4;

  localparam int DAYS_W = 17;  // signed day count, -1 up to past the span
  localparam int TIME_W = 19;  // signed time-of-day seconds after the shift, may cross a day edge

  // Cumulative days at the start of each month over a four-year cycle.
  localparam logic [10:0] CUM_DAYS [4][12] = '{
    '{11'd0,    11'd31,   11'd60,   11'd91,   11'd121,  11'd152,
      11'd182,  11'd213,  11'd244,  11'd274,  11'd305,  11'd335},
    '{11'd366,  11'd397,  11'd425,  11'd456,  11'd486,  11'd517,
      11'd547,  11'd578,  11'd609,  11'd639,  11'd670,  11'd700},
    '{11'd731,  11'd762,  11'd790,  11'd821,  11'd851,  11'd882,
      11'd912,  11'd943,  11'd974,  11'd1004, 11'd1035, 11'd1065},
    '{11'd1096, 11'd1127, 11'd1155, 11'd1186, 11'd1216, 11'd1247,
      11'd1277, 11'd1308, 11'd1339, 11'd1369, 11'd1400, 11'd1430}
  };

  typedef struct packed {
    logic                     err;
    logic signed [DAYS_W-1:0] days;
    logic signed [TIME_W-1:0] secs;
    logic [9:0]               millis;
  } cts_entry_t;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  date;
    logic [2:0]  weekday;
    logic [4:0]  hours;
    logic [5:0]  minutes;
    logic [5:0]  seconds;
    logic [9:0]  millis;
    logic        range_error;
  } cts_result_t;

endpackage

// ===== hdl/cts_front.sv =====
// Front end: checks an incoming date and reduces it to a day count and shifted seconds.
module cts_front
  import cts_pkg::*;
(
  input  logic              kind,
  input  logic [11:0]       in_year,
  input  logic [3:0]        in_month,
  input  logic [4:0]        in_date,
  input  logic [4:0]        in_hours,
  input  logic [5:0]        in_minutes,
  input  logic [5:0]        in_seconds,
  input  logic [9:0]        in_millis,
  input  logic signed [8:0] zone_offset,
  output cts_entry_t        entry
);

  logic                     in_ok;
  logic [11:0]              year_rel;
  logic [3:0]               month_idx;
  logic [DAYS_W-1:0]        day_sum;
  logic                     carry;
  logic [TIME_W-1:0]        tod;
  logic signed [TIME_W-1:0] off_ext;
  logic signed [TIME_W-1:0] shift;

  always_comb begin
    in_ok = (in_year >= 12'(BASE_YEAR)) && (in_year <= 12'(LAST_YEAR)) &&
            (in_month >= 4'd1) && (in_month <= 4'd12);
    year_rel  = in_year - 12'(BASE_YEAR);
    month_idx = in_ok ? (in_month - 4'd1) : 4'd0;
    day_sum   = DAYS_W'(year_rel[6:2]) * DAYS_W'(DAYS_PER_QUAD) +
                DAYS_W'(CUM_DAYS[year_rel[1:0]][month_idx]) +
                DAYS_W'(in_date) - DAYS_W'(1);
    carry = (in_millis >= 10'(MILLIS_PER_SEC));
    tod   = TIME_W'(in_hours) * TIME_W'(SECS_PER_HOUR) +
            TIME_W'(in_minutes) * TIME_W'(SECS_PER_MIN) +
            TIME_W'(in_seconds) + TIME_W'(carry);
    off_ext = {{(TIME_W-9){zone_offset[8]}}, zone_offset};
    shift   = off_ext * $signed(TIME_W'(ZONE_UNIT_SECS));
    entry.err    = !in_ok;
    entry.days   = $signed(day_sum);
    entry.secs   = kind ? ($signed(tod) - shift) : ($signed(tod) + shift);
    entry.millis = carry ? (in_millis - 10'(MILLIS_PER_SEC)) : in_millis;
  end

endmodule

// ===== hdl/cts_queue.sv =====
// Short first-in first-out queue between the front end and the conversion pipeline.
module cts_queue
  import cts_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       wr,
  input  cts_entry_t wr_data,
  output logic       full,
  input  logic       rd,
  output cts_entry_t rd_data,
  output logic       empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cts_entry_t    slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_wr;
  logic          do_rd;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr && !full;
  assign do_rd   = rd && !empty;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      count <= count + CW'(do_wr) - CW'(do_rd);
    end
  end

endmodule

// ===== hdl/cts_back.sv =====
// Back end: seven-stage pipeline that turns a day count and seconds back into a date.
module cts_back
  import cts_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cts_entry_t  head,
  input  logic        head_valid,
  output logic        head_take,
  output cts_result_t result,
  output logic        result_valid,
  input  logic        result_pop
);

  logic [6:0] vld;
  logic       en;

  assign en           = !vld[6] || result_pop;
  assign head_take    = en && head_valid;
  assign result_valid = vld[6];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[5:0], head_valid};
    end
  end

  // Stage 0: fold the shifted seconds into the day count.
  logic signed [DAYS_W:0]   dadj;
  logic signed [TIME_W-1:0] tadj;
  logic [15:0] d0;
  logic [16:0] tod0;
  logic        e0;
  logic [9:0]  ms0;

  always_comb begin
    if (head.secs < -$signed(TIME_W'(SECS_PER_DAY))) begin
      dadj = $signed({head.days[DAYS_W-1], head.days}) - $signed((DAYS_W+1)'(2));
      tadj = head.secs + $signed(TIME_W'(2 * SECS_PER_DAY));
    end else if (head.secs < 0) begin
      dadj = $signed({head.days[DAYS_W-1], head.days}) - $signed((DAYS_W+1)'(1));
      tadj = head.secs + $signed(TIME_W'(SECS_PER_DAY));
    end else if (head.secs >= $signed(TIME_W'(2 * SECS_PER_DAY))) begin
      dadj = $signed({head.days[DAYS_W-1], head.days}) + $signed((DAYS_W+1)'(2));
      tadj = head.secs - $signed(TIME_W'(2 * SECS_PER_DAY));
    end else if (head.secs >= $signed(TIME_W'(SECS_PER_DAY))) begin
      dadj = $signed({head.days[DAYS_W-1], head.days}) + $signed((DAYS_W+1)'(1));
      tadj = head.secs - $signed(TIME_W'(SECS_PER_DAY));
    end else begin
      dadj = $signed({head.days[DAYS_W-1], head.days});
      tadj = head.secs;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d0   <= dadj[15:0];
      tod0 <= tadj[16:0];
      e0   <= head.err || (dadj < 0) || (dadj >= $signed((DAYS_W+1)'(SPAN_DAYS)));
      ms0  <= head.millis;
    end
  end

  // Stage 1: reciprocal estimates of the quotients.
  logic [15:0] d1;
  logic [16:0] tod1;
  logic        e1;
  logic [9:0]  ms1;
  logic [4:0]  qy1;
  logic [4:0]  qh1;
  logic [12:0] qw1;
  logic [31:0] py;
  logic [31:0] ph;
  logic [31:0] pw;

  always_comb begin
    py = 32'(d0) * 32'(QUAD_RECIP);
    ph = 32'(tod0) * 32'(HOUR_RECIP);
    pw = (32'(d0) + 32'(WEEKDAY_BIAS)) * 32'(WEEK_RECIP);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1   <= d0;
      tod1 <= tod0;
      e1   <= e0;
      ms1  <= ms0;
      qy1  <= py[QUAD_SHIFT+4:QUAD_SHIFT];
      qh1  <= ph[HOUR_SHIFT+4:HOUR_SHIFT];
      qw1  <= pw[WEEK_SHIFT+12:WEEK_SHIFT];
    end
  end

  // Stage 2: remainders of the estimates.
  logic        e2;
  logic [9:0]  ms2;
  logic [4:0]  qy2;
  logic [4:0]  qh2;
  logic [11:0] ry2;
  logic [12:0] rh2;
  logic [3:0]  rw2;
  logic [16:0] ry_full;
  logic [16:0] rh_full;
  logic [16:0] rw_full;

  always_comb begin
    ry_full = 17'(d1) - 17'(qy1) * 17'(DAYS_PER_QUAD);
    rh_full = tod1 - 17'(qh1) * 17'(SECS_PER_HOUR);
    rw_full = 17'(d1) + 17'(WEEKDAY_BIAS) - 17'(qw1) * 17'd7;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e2  <= e1;
      ms2 <= ms1;
      qy2 <= qy1;
      qh2 <= qh1;
      ry2 <= ry_full[11:0];
      rh2 <= rh_full[12:0];
      rw2 <= rw_full[3:0];
    end
  end

  // Stage 3: one correction step brings each remainder below its divisor.
  logic        e3;
  logic [9:0]  ms3;
  logic [4:0]  qy3;
  logic [10:0] rem3;
  logic [4:0]  hr3;
  logic [11:0] tod3;
  logic [2:0]  wd3;

  always_ff @(posedge clk) begin
    if (en) begin
      e3  <= e2;
      ms3 <= ms2;
      if (ry2 >= 12'(DAYS_PER_QUAD)) begin
        qy3  <= qy2 + 5'd1;
        rem3 <= 11'(ry2 - 12'(DAYS_PER_QUAD));
      end else begin
        qy3  <= qy2;
        rem3 <= ry2[10:0];
      end
      if (rh2 >= 13'(SECS_PER_HOUR)) begin
        hr3  <= qh2 + 5'd1;
        tod3 <= 12'(rh2 - 13'(SECS_PER_HOUR));
      end else begin
        hr3  <= qh2;
        tod3 <= rh2[11:0];
      end
      wd3 <= (rw2 >= 4'd7) ? 3'(rw2 - 4'd7) : rw2[2:0];
    end
  end

  // Stage 4: year within the cycle, minute estimate.
  logic        e4;
  logic [9:0]  ms4;
  logic [4:0]  qy4;
  logic [10:0] rem4;
  logic [1:0]  yi4;
  logic [4:0]  hr4;
  logic [11:0] tod4;
  logic [2:0]  wd4;
  logic [5:0]  qm4;
  logic [1:0]  yi_sel;
  logic [19:0] pm;

  always_comb begin
    priority if (rem3 >= CUM_DAYS[3][0]) begin
      yi_sel = 2'd3;
    end else if (rem3 >= CUM_DAYS[2][0]) begin
      yi_sel = 2'd2;
    end else if (rem3 >= CUM_DAYS[1][0]) begin
      yi_sel = 2'd1;
    end else begin
      yi_sel = 2'd0;
    end
    pm = 20'(tod3) * 20'(MIN_RECIP);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e4   <= e3;
      ms4  <= ms3;
      qy4  <= qy3;
      rem4 <= rem3;
      yi4  <= yi_sel;
      hr4  <= hr3;
      tod4 <= tod3;
      wd4  <= wd3;
      qm4  <= pm[MIN_SHIFT+5:MIN_SHIFT];
    end
  end

  // Stage 5: month search over the selected row, minute remainder.
  logic        e5;
  logic [9:0]  ms5;
  logic [4:0]  qy5;
  logic [10:0] rem5;
  logic [1:0]  yi5;
  logic [3:0]  mi5;
  logic [4:0]  hr5;
  logic [5:0]  qm5;
  logic [6:0]  rm5;
  logic [2:0]  wd5;
  logic [3:0]  mi_sel;
  logic [11:0] rm_full;

  always_comb begin
    mi_sel = 4'd0;
    for (int j = 0; j < 12; j++) begin
      if (rem4 >= CUM_DAYS[yi4][j]) begin
        mi_sel = 4'(j);
      end
    end
    rm_full = tod4 - 12'(qm4) * 12'(SECS_PER_MIN);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e5   <= e4;
      ms5  <= ms4;
      qy5  <= qy4;
      rem5 <= rem4;
      yi5  <= yi4;
      mi5  <= mi_sel;
      hr5  <= hr4;
      qm5  <= qm4;
      rm5  <= rm_full[6:0];
      wd5  <= wd4;
    end
  end

  // Stage 6: assemble the result; this register is the output slot.
  cts_result_t res_next;
  logic [10:0] day_in_month;

  always_comb begin
    day_in_month = rem5 - CUM_DAYS[yi5][mi5] + 11'd1;
    res_next.year    = 12'(qy5) * 12'd4 + 12'(yi5) + 12'(BASE_YEAR);
    res_next.month   = mi5 + 4'd1;
    res_next.date    = day_in_month[4:0];
    res_next.weekday = wd5 + 3'd1;
    res_next.hours   = hr5;
    if (rm5 >= 7'(SECS_PER_MIN)) begin
      res_next.minutes = qm5 + 6'd1;
      res_next.seconds = 6'(rm5 - 7'(SECS_PER_MIN));
    end else begin
      res_next.minutes = qm5;
      res_next.seconds = rm5[5:0];
    end
    res_next.millis      = ms5;
    res_next.range_error = 1'b0;
    if (e5) begin
      res_next             = '0;
      res_next.range_error = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result <= res_next;
    end
  end

endmodule

// ===== hdl/calendar_timezone_shift.sv =====
// Top level of the calendar timezone shift block: ports, offset register and checks.
//
// Converts a calendar date and time in the years 2000 to 2099 between UTC and local
// time. Each input beat carries a date, a time of day with milliseconds and a kind
// bit: kind 0 adds the configured zone offset (UTC to local), kind 1 subtracts it.
// The offset is written through the cfg port in units of six minutes, signed, and
// must only be changed while no beat is in flight. Out-of-range fields are counted
// linearly, so day 0 is the last day of the previous month and a millisecond value
// of 1000 or more carries one second. An input year or month that is invalid, or a
// shifted time outside 2000-01-01 to 2099-12-31, returns a beat with range_error set
// and all other fields zero. One beat is accepted every cycle while the input queue
// is not full; each result passes through the input queue and the stages of the
// conversion pipeline before it is shown. A short queue behind the input holds up to
// QUEUE_DEPTH beats while the output is not popped and the pipeline is stalled.
module calendar_timezone_shift
  import cts_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration write channel for the zone offset.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [8:0]  cfg_data,
  // Input queue side.
  input  logic        push,
  output logic        full,
  input  logic        kind,
  input  logic [11:0] in_year,
  input  logic [3:0]  in_month,
  input  logic [4:0]  in_date,
  input  logic [4:0]  in_hours,
  input  logic [5:0]  in_minutes,
  input  logic [5:0]  in_seconds,
  input  logic [9:0]  in_millis,
  // Result queue side.
  output logic        empty,
  input  logic        pop,
  output logic [11:0] out_year,
  output logic [3:0]  out_month,
  output logic [4:0]  out_date,
  output logic [2:0]  out_weekday,
  output logic [4:0]  out_hours,
  output logic [5:0]  out_minutes,
  output logic [5:0]  out_seconds,
  output logic [9:0]  out_millis,
  output logic        range_error
);

  logic signed [8:0] zone_offset;
  cts_entry_t        front_entry;
  cts_entry_t        head;
  logic              q_empty;
  logic              head_take;
  cts_result_t       result;
  logic              result_valid;

  // The offset register takes a write in every cycle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      zone_offset <= '0;
    end else if (cfg_valid) begin
      zone_offset <= $signed(cfg_data);
    end
  end

  // The front end classifies the beat and folds date and time into a day count
  // plus a signed seconds value that already includes the zone shift.
  cts_front u_front (
    .kind        (kind),
    .in_year     (in_year),
    .in_month    (in_month),
    .in_date     (in_date),
    .in_hours    (in_hours),
    .in_minutes  (in_minutes),
    .in_seconds  (in_seconds),
    .in_millis   (in_millis),
    .zone_offset (zone_offset),
    .entry       (front_entry)
  );

  // The queue decouples input acceptance from a stalled result side.
  cts_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (push),
    .wr_data (front_entry),
    .full    (full),
    .rd      (head_take),
    .rd_data (head),
    .empty   (q_empty)
  );

  // The back end splits days into years, months and weekday and seconds into
  // hours, minutes and seconds; its last register holds the result shown.
  cts_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .head_valid   (!q_empty),
    .head_take    (head_take),
    .result       (result),
    .result_valid (result_valid),
    .result_pop   (pop)
  );

  assign empty       = !result_valid;
  assign out_year    = result.year;
  assign out_month   = result.month;
  assign out_date    = result.date;
  assign out_weekday = result.weekday;
  assign out_hours   = result.hours;
  assign out_minutes = result.minutes;
  assign out_seconds = result.seconds;
  assign out_millis  = result.millis;
  assign range_error = result.range_error;

  // An error beat carries no date.
  assert property (@(posedge clk) disable iff (rst)
    (!empty && range_error) |-> (out_year == 12'd0 && out_month == 4'd0 &&
                                 out_weekday == 3'd0 && out_hours == 5'd0))
    else $error("error beat carries a nonzero date");

  // A good beat has year, month and weekday in range and a date of at least 1.
  assert property (@(posedge clk) disable iff (rst)
    (!empty && !range_error) |->
      (out_year >= 12'(BASE_YEAR) && out_year <= 12'(LAST_YEAR) &&
       out_month >= 4'd1 && out_month <= 4'd12 && out_date >= 5'd1 &&
       out_weekday >= 3'd1 && out_weekday <= 3'd7))
    else $error("result date out of range");

  // Time of day and milliseconds are always normalized.
  assert property (@(posedge clk) disable iff (rst)
    !empty |-> (out_hours < 5'd24 && out_minutes < 6'd60 &&
                out_seconds < 6'd60 && out_millis < 10'd1000))
    else $error("result time not normalized");

  // A result waiting to be popped is not overwritten by the pipeline.
  assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(out_year) && $stable(out_seconds)))
    else $error("waiting result changed");

endmodule

// ===== tb/sv/tb_calendar_timezone_shift.sv =====
// Testbench of the calendar timezone shift block with its conversion scoreboard.
`timescale 1ns / 100ps

// Scoreboard: predicts each converted date from the accepted input beat and
// checks the result beats in order against those predictions.
class zone_shift_scoreboard;
  cts_pkg::cts_result_t pending_dates[$];
  logic signed [8:0]    zone_offset;
  int                   error_count;
  int                   checked_count;
  int                   range_count;

  function new();
    zone_offset   = '0;
    error_count   = 0;
    checked_count = 0;
    range_count   = 0;
  endfunction

  // Zeller's rule, shifted so that 1 is Monday and 7 is Sunday.
  function automatic int day_of_week(int yr, int mo, int dd);
    int k;
    int j;
    int h;
    if (mo <= 2) begin
      mo = mo + 12;
      yr = yr - 1;
    end
    k = yr % 100;
    j = yr / 100;
    h = (dd + (13 * (mo + 1)) / 5 + k + k / 4 + j / 4 + 5 * j) % 7;
    return (h + 5) % 7 + 1;
  endfunction

  function automatic void note_input(logic kd, logic [11:0] yr, logic [3:0] mo,
                                     logic [4:0] dd, logic [4:0] hh, logic [5:0] mm,
                                     logic [5:0] ss, logic [9:0] ms);
    cts_pkg::cts_result_t r;
    longint days;
    longint secs;
    longint shift;
    int yoff;
    int rem;
    int yi;
    int mi;
    int full_year;
    int ms_left;
    r = '0;
    r.range_error = 1'b1;
    if (yr >= cts_pkg::BASE_YEAR && yr <= cts_pkg::LAST_YEAR && mo >= 1 && mo <= 12) begin
      yoff = int'(yr) - cts_pkg::BASE_YEAR;
      days = longint'(yoff / 4) * cts_pkg::DAYS_PER_QUAD
           + longint'(cts_pkg::CUM_DAYS[yoff % 4][int'(mo) - 1]) + longint'(dd) - 1;
      secs = ((days * 24 + longint'(hh)) * 60 + longint'(mm)) * 60 + longint'(ss);
      ms_left = int'(ms);
      if (ms_left >= 1000) begin
        secs++;
        ms_left -= 1000;
      end
      shift = longint'(zone_offset) * cts_pkg::ZONE_UNIT_SECS;
      secs = kd ? secs - shift : secs + shift;
      if (secs >= 0 && secs < longint'(cts_pkg::SPAN_DAYS) * cts_pkg::SECS_PER_DAY) begin
        r.seconds = 6'(secs % 60);
        secs /= 60;
        r.minutes = 6'(secs % 60);
        secs /= 60;
        r.hours = 5'(secs % 24);
        secs /= 24;
        rem = int'(secs % cts_pkg::DAYS_PER_QUAD);
        for (yi = 3; yi > 0; yi--)
          if (rem >= cts_pkg::CUM_DAYS[yi][0]) break;
        for (mi = 11; mi > 0; mi--)
          if (rem >= cts_pkg::CUM_DAYS[yi][mi]) break;
        full_year = int'(secs / cts_pkg::DAYS_PER_QUAD) * 4 + yi + cts_pkg::BASE_YEAR;
        r.year = 12'(full_year);
        r.month = 4'(mi + 1);
        r.date = 5'(rem - int'(cts_pkg::CUM_DAYS[yi][mi]) + 1);
        r.weekday = 3'(day_of_week(full_year, mi + 1, int'(r.date)));
        r.millis = 10'(ms_left);
        r.range_error = 1'b0;
      end
    end
    pending_dates.push_back(r);
  endfunction

  function automatic void check_result(cts_pkg::cts_result_t got);
    cts_pkg::cts_result_t want;
    if (pending_dates.size() == 0) begin
      $display("%0t: result beat with no prediction waiting: %p", $time, got);
      error_count++;
      return;
    end
    want = pending_dates.pop_front();
    checked_count++;
    if (want.range_error) range_count++;
    if (got.year !== want.year)
      $display("%0t: year expected %0d actual %0d", $time, want.year, got.year);
    if (got.month !== want.month)
      $display("%0t: month expected %0d actual %0d", $time, want.month, got.month);
    if (got.date !== want.date)
      $display("%0t: date expected %0d actual %0d", $time, want.date, got.date);
    if (got.weekday !== want.weekday)
      $display("%0t: weekday expected %0d actual %0d", $time, want.weekday, got.weekday);
    if (got.hours !== want.hours)
      $display("%0t: hours expected %0d actual %0d", $time, want.hours, got.hours);
    if (got.minutes !== want.minutes)
      $display("%0t: minutes expected %0d actual %0d", $time, want.minutes, got.minutes);
    if (got.seconds !== want.seconds)
      $display("%0t: seconds expected %0d actual %0d", $time, want.seconds, got.seconds);
    if (got.millis !== want.millis)
      $display("%0t: millis expected %0d actual %0d", $time, want.millis, got.millis);
    if (got.range_error !== want.range_error)
      $display("%0t: range_error expected %0b actual %0b", $time,
               want.range_error, got.range_error);
    if (got !== want) error_count++;
  endfunction
endclass

module tb_calendar_timezone_shift;
  import cts_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [8:0]  cfg_data = '0;
  logic        push = 1'b0;
  logic        full;
  logic        kind = 1'b0;
  logic [11:0] in_year = 12'd2000;
  logic [3:0]  in_month = 4'd1;
  logic [4:0]  in_date = 5'd1;
  logic [4:0]  in_hours = '0;
  logic [5:0]  in_minutes = '0;
  logic [5:0]  in_seconds = '0;
  logic [9:0]  in_millis = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [11:0] out_year;
  logic [3:0]  out_month;
  logic [4:0]  out_date;
  logic [2:0]  out_weekday;
  logic [4:0]  out_hours;
  logic [5:0]  out_minutes;
  logic [5:0]  out_seconds;
  logic [9:0]  out_millis;
  logic        range_error;

  // Extra wait after the last result, so the block is idle before the next phase.
  localparam int DRAIN_CYCLES = 40;

  zone_shift_scoreboard dates;
  bit stimulus_done = 1'b0;
  bit reset_done = 1'b0;
  int beats_pushed = 0;

  always #6 clk = ~clk;

  calendar_timezone_shift i_dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .push(push), .full(full), .kind(kind),
    .in_year(in_year), .in_month(in_month), .in_date(in_date),
    .in_hours(in_hours), .in_minutes(in_minutes), .in_seconds(in_seconds),
    .in_millis(in_millis),
    .empty(empty), .pop(pop),
    .out_year(out_year), .out_month(out_month), .out_date(out_date),
    .out_weekday(out_weekday), .out_hours(out_hours), .out_minutes(out_minutes),
    .out_seconds(out_seconds), .out_millis(out_millis), .range_error(range_error)
  );

  // Gap length for either side: mostly zero or short, now and then long.
  function automatic int idle_gap();
    int pick;
    pick = $urandom_range(99);
    if (pick < 55) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Writes the zone offset while the block is idle and mirrors it in the scoreboard.
  task automatic write_offset(int offset);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= offset[8:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    dates.zone_offset = offset[8:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Presents one input beat and holds it until the block takes it. Push stays
  // high across back-to-back beats so it is never dropped and raised in one step.
  task automatic push_date(logic kd, logic [11:0] yr, logic [3:0] mo, logic [4:0] dd,
                           logic [4:0] hh, logic [5:0] mm, logic [5:0] ss,
                           logic [9:0] ms);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push       <= 1'b1;
    kind       <= kd;
    in_year    <= yr;
    in_month   <= mo;
    in_date    <= dd;
    in_hours   <= hh;
    in_minutes <= mm;
    in_seconds <= ss;
    in_millis  <= ms;
    @(posedge clk);
    while (full) @(posedge clk);
    dates.note_input(kd, yr, mo, dd, hh, mm, ss, ms);
    beats_pushed++;
    @(negedge clk);
  endtask

  task automatic end_burst();
    push <= 1'b0;
  endtask

  // Waits for every predicted result, then the drain wait, so nothing is in flight.
  task automatic wait_idle();
    end_burst();
    while (dates.pending_dates.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // A well-formed date and time, with an occasional beat of random bit patterns.
  task automatic push_random_date();
    logic [11:0] yr;
    logic [3:0]  mo;
    logic [4:0]  dd;
    logic [4:0]  hh;
    logic [5:0]  mm;
    logic [5:0]  ss;
    logic [9:0]  ms;
    int pick;
    pick = $urandom_range(99);
    yr = 12'($urandom_range(LAST_YEAR, BASE_YEAR));
    // Lean on the span edges, where the shift can leave the covered years.
    if (pick < 15) yr = (pick < 8) ? 12'(BASE_YEAR) : 12'(LAST_YEAR);
    mo = 4'($urandom_range(12, 1));
    dd = 5'($urandom_range(28, 1));
    if (pick < 25 && pick >= 15) begin
      mo = (pick < 20) ? 4'd1 : 4'd12;
      dd = (pick < 20) ? 5'd1 : 5'd31;
    end
    hh = 5'($urandom_range(23));
    mm = 6'($urandom_range(59));
    ss = 6'($urandom_range(59));
    ms = 10'($urandom_range(999));
    if (pick >= 85) begin
      // Noise: any bit pattern in every field; the year only now and then.
      yr = (pick >= 97) ? 12'($urandom()) : yr;
      mo = 4'($urandom());
      dd = 5'($urandom());
      hh = 5'($urandom());
      mm = 6'($urandom());
      ss = 6'($urandom());
      ms = 10'($urandom());
    end
    push_date(1'($urandom_range(1)), yr, mo, dd, hh, mm, ss, ms);
  endtask

  // Result side: pop with random stalls and hand each beat to the scoreboard.
  initial begin
    cts_result_t got;
    int gap;
    @(negedge clk);
    while (!reset_done) @(negedge clk);
    forever begin
      gap = idle_gap();
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      if (!empty) begin
        got = '{out_year, out_month, out_date, out_weekday, out_hours, out_minutes,
                out_seconds, out_millis, range_error};
        dates.check_result(got);
      end
      @(negedge clk);
    end
  end

  // Stimulus: directed corner cases under several offsets, then random phases.
  initial begin
    int offsets[$];
    dates = new();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    reset_done = 1'b1;

    // Directed: extremes of the offset and of every field.
    write_offset(140);
    push_date(1'b0, 12'd2099, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59, 10'd999); // leaves span
    push_date(1'b1, 12'd2099, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59, 10'd999);
    push_date(1'b1, 12'd2000, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 10'd0);        // before 2000
    push_date(1'b0, 12'd2000, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 10'd0);
    push_date(1'b0, 12'd2024, 4'd2, 5'd29, 5'd12, 6'd30, 6'd0, 10'd500);   // leap day
    wait_idle();
    write_offset(-120);
    push_date(1'b0, 12'd2000, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 10'd0);
    push_date(1'b1, 12'd2099, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59, 10'd0);
    push_date(1'b0, 12'd1999, 4'd6, 5'd1, 5'd0, 6'd0, 6'd0, 10'd0);        // bad year
    push_date(1'b0, 12'd2100, 4'd6, 5'd1, 5'd0, 6'd0, 6'd0, 10'd0);
    push_date(1'b0, 12'd2050, 4'd0, 5'd1, 5'd0, 6'd0, 6'd0, 10'd0);        // bad month
    push_date(1'b0, 12'd2050, 4'd13, 5'd1, 5'd0, 6'd0, 6'd0, 10'd0);
    push_date(1'b1, 12'd4095, 4'd15, 5'd31, 5'd31, 6'd63, 6'd63, 10'd1023);
    wait_idle();
    write_offset(0);
    push_date(1'b0, 12'd2023, 4'd2, 5'd31, 5'd0, 6'd0, 6'd0, 10'd0);       // past month end
    push_date(1'b0, 12'd2024, 4'd3, 5'd0, 5'd0, 6'd0, 6'd0, 10'd0);        // day zero
    push_date(1'b0, 12'd2001, 4'd1, 5'd0, 5'd31, 6'd63, 6'd63, 10'd1023);  // overlong time
    push_date(1'b1, 12'd2000, 4'd1, 5'd0, 5'd0, 6'd0, 6'd0, 10'd0);        // day before span
    push_date(1'b0, 12'd2099, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59, 10'd1000); // millis carry
    push_date(1'b1, 12'd2077, 4'd7, 5'd15, 5'd23, 6'd59, 6'd59, 10'd999);
    push_date(1'b0, 12'd2100, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0, 10'd0);
    wait_idle();

    // Random phases, each under its own offset, extremes and the sign bit among them.
    offsets = '{1, -1, 140, -120, 255, -256, 37, -53, 0, 10};
    foreach (offsets[p]) begin
      write_offset(offsets[p]);
      repeat (145) push_random_date();
      wait_idle();
    end
    stimulus_done = 1'b1;
  end

  // Final verdict once the stimulus has drained.
  initial begin
    while (!stimulus_done) @(negedge clk);
    $display("Converted %0d date beats over %0d offset settings; %0d gave range errors.",
             dates.checked_count, 13, dates.range_count);
    if (dates.error_count == 0 && dates.pending_dates.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog in case a handshake never completes.
  initial begin
    #5ms;
    $display("Timeout after %0d input beats.", beats_pushed);
    $display("CHECKS FAILED");
    $finish;
  end
endmodule
